// ===== rtl/cn_pkg.sv =====
// Shared types, constants and the divider step for the chromaticity normalizer.
`timescale 1ns / 1ps

package cn_pkg;

  localparam int unsigned CH_W           = 8;   // channel sample width
  localparam int unsigned SUM_W          = 10;  // r+g+b, 0..765
  localparam int unsigned PROD_W         = 16;  // 255*channel
  localparam int unsigned LANES          = 3;
  localparam int unsigned BITS_PER_STAGE = 2;   // quotient bits per pipe stage
  localparam int unsigned DIV_STAGES     = CH_W / BITS_PER_STAGE;

  // floor(sum/3) == (sum*683) >> 11 for every sum up to 765
  localparam int unsigned THIRD_SHIFT = 11;
  localparam logic [SUM_W-1:0] THIRD_RECIP = SUM_W'(683);

  localparam int unsigned LANE_R = 0;
  localparam int unsigned LANE_G = 1;
  localparam int unsigned LANE_B = 2;

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef enum logic {
    MODE_NORM      = 1'b0,
    MODE_INTENSITY = 1'b1
  } mode_t;

  // Word carried down the divider pipeline
  typedef struct packed {
    sum_t  [LANES-1:0] rem;        // partial remainder, below den unless the pixel is black
    chan_t [LANES-1:0] low;        // numerator bits not yet shifted in
    chan_t [LANES-1:0] quo;        // quotient bits so far
    sum_t              den;        // pixel sum
    chan_t             intensity;  // floor(sum/3)
    logic              zero;       // black pixel
    mode_t             mode;
  } div_word_t;

  // One restoring-division step on every lane
  function automatic div_word_t div_step(input div_word_t w);
    div_word_t        o;
    logic [SUM_W:0]   t;
    logic             take;
    o = w;
    for (int k = 0; k < LANES; k++) begin
      t    = {w.rem[k], w.low[k][CH_W-1]};
      take = (t >= {1'b0, w.den});
      o.rem[k] = take ? SUM_W'(t - {1'b0, w.den}) : t[SUM_W-1:0];
      o.low[k] = {w.low[k][CH_W-2:0], 1'b0};
      o.quo[k] = {w.quo[k][CH_W-2:0], take};
    end
    return o;
  endfunction

endpackage

// ===== rtl/cn_front.sv =====
// Input stage: pixel sum, scaled numerators and intensity.
`timescale 1ns / 1ps

module cn_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  input  cn_pkg::chan_t     red,
  input  cn_pkg::chan_t     green,
  input  cn_pkg::chan_t     blue,
  input  cn_pkg::mode_t     mode,
  input  logic              dn_ready,
  output logic              up_ready,
  output logic              valid_r,
  output cn_pkg::div_word_t data_r
);

  cn_pkg::div_word_t                  data_nxt;
  cn_pkg::sum_t                       sum;
  logic [cn_pkg::PROD_W-1:0]          prod [cn_pkg::LANES];
  logic [2*cn_pkg::SUM_W-1:0]         third_prod;
  cn_pkg::chan_t                      chans [cn_pkg::LANES];

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    chans[cn_pkg::LANE_R] = red;
    chans[cn_pkg::LANE_G] = green;
    chans[cn_pkg::LANE_B] = blue;
    sum = cn_pkg::SUM_W'(red) + cn_pkg::SUM_W'(green) + cn_pkg::SUM_W'(blue);
    third_prod = (2*cn_pkg::SUM_W)'(sum) * (2*cn_pkg::SUM_W)'(cn_pkg::THIRD_RECIP);
    data_nxt.den       = sum;
    data_nxt.zero      = (sum == '0);
    data_nxt.mode      = mode;
    data_nxt.intensity =
      third_prod[cn_pkg::THIRD_SHIFT+cn_pkg::CH_W-1:cn_pkg::THIRD_SHIFT];
    for (int k = 0; k < cn_pkg::LANES; k++) begin
      // 255*c = (c << 8) - c; high byte is already below a nonzero sum
      prod[k] = {chans[k], cn_pkg::CH_W'(0)} - {cn_pkg::CH_W'(0), chans[k]};
      data_nxt.rem[k] = cn_pkg::SUM_W'(prod[k][cn_pkg::PROD_W-1:cn_pkg::CH_W]);
      data_nxt.low[k] = prod[k][cn_pkg::CH_W-1:0];
      data_nxt.quo[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/cn_div_stage.sv =====
// One divider pipe stage: two quotient bits on all three lanes.
`timescale 1ns / 1ps

module cn_div_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  input  cn_pkg::div_word_t up_data,
  input  logic              dn_ready,
  output logic              up_ready,
  output logic              valid_r,
  output cn_pkg::div_word_t data_r
);

  cn_pkg::div_word_t data_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    data_nxt = up_data;
    for (int s = 0; s < cn_pkg::BITS_PER_STAGE; s++) begin
      data_nxt = cn_pkg::div_step(data_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  // remainder stays below divisor on a nonzero pixel
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !data_r.zero) |->
      (data_r.rem[cn_pkg::LANE_R] < data_r.den) &&
      (data_r.rem[cn_pkg::LANE_G] < data_r.den) &&
      (data_r.rem[cn_pkg::LANE_B] < data_r.den))
    else $error("divider remainder not below sum");

  // a blocked stage keeps its word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !dn_ready) |=> (valid_r && $stable(data_r)))
    else $error("stalled divider stage lost its word");

endmodule

// ===== rtl/chromaticity_normalizer.sv =====
// Top: normalized RGB chromaticity or intensity; one pixel/clock unless stalled.
`timescale 1ns / 1ps

//  channel  handshake                 payload
//  in       in_valid / in_stall       in_red, in_green, in_blue (8b each)
//  out      out_valid / out_stall     out_first, out_second, out_third (8b each)
//  cfg      cfg_valid / cfg_ready     cfg_mode (1b)
//
//  One pixel per clock sustained unless stalled; path: input stage + 4 divider
//  stages (2 quotient bits each), all registered. The radix-2 divider stages set the depth.
//  rst_n is synchronous: clears all stage valids and sets mode to normalized.
//  Stalls ripple back stage by stage; empty stages still fill, so in_stall
//  rises only when every stage holds a request.

module chromaticity_normalizer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cn_pkg::chan_t in_red,
  input  cn_pkg::chan_t in_green,
  input  cn_pkg::chan_t in_blue,
  output logic          out_valid,
  input  logic          out_stall,
  output cn_pkg::chan_t out_first,
  output cn_pkg::chan_t out_second,
  output cn_pkg::chan_t out_third,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_mode
);

  cn_pkg::mode_t      mode_r;
  logic [cn_pkg::DIV_STAGES:0]   stg_valid;
  logic [cn_pkg::DIV_STAGES+1:0] stg_ready;   // top entry is the sink
  cn_pkg::div_word_t  stg_data [cn_pkg::DIV_STAGES+1];
  cn_pkg::div_word_t  fin;
  logic               in_acc;
  logic               out_acc;

  // mode register; the user must write it only while idle, the block does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= cn_pkg::MODE_NORM;
    end else if (cfg_valid) begin
      mode_r <= cn_pkg::mode_t'(cfg_mode);
    end
  end

  // stage 0: sum, 255*channel, intensity
  cn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .red      (in_red),
    .green    (in_green),
    .blue     (in_blue),
    .mode     (mode_r),
    .dn_ready (stg_ready[1]),
    .up_ready (stg_ready[0]),
    .valid_r  (stg_valid[0]),
    .data_r   (stg_data[0])
  );

  // stages 1..4: restoring division, MSB first
  for (genvar i = 1; i <= cn_pkg::DIV_STAGES; i++) begin : g_div
    cn_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[i-1]),
      .up_data  (stg_data[i-1]),
      .dn_ready (stg_ready[i+1]),
      .up_ready (stg_ready[i]),
      .valid_r  (stg_valid[i]),
      .data_r   (stg_data[i])
    );
  end

  assign stg_ready[cn_pkg::DIV_STAGES+1] = !out_stall;
  assign in_stall = !stg_ready[0];

  // last stage register is the output register
  assign fin       = stg_data[cn_pkg::DIV_STAGES];
  assign out_valid = stg_valid[cn_pkg::DIV_STAGES];

  // black pixel forces zeros; divider would give all ones with a zero sum
  always_comb begin
    if (fin.zero) begin
      out_first  = '0;
      out_second = '0;
      out_third  = '0;
    end else if (fin.mode == cn_pkg::MODE_INTENSITY) begin
      out_first  = fin.intensity;
      out_second = fin.quo[cn_pkg::LANE_R];
      out_third  = fin.quo[cn_pkg::LANE_G];
    end else begin
      out_first  = fin.quo[cn_pkg::LANE_R];
      out_second = fin.quo[cn_pkg::LANE_G];
      out_third  = fin.quo[cn_pkg::LANE_B];
    end
  end

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // back-pressure only when the whole pipe is full
  a_full_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&stg_valid))
    else $error("input stalled with an empty stage");

  // requests in flight change only by accepts at either end
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (int'($countones(stg_valid)) ==
              int'($past($countones(stg_valid))) + int'($past(in_acc))
              - int'($past(out_acc))))
    else $error("request lost or duplicated in pipe");

endmodule
